// File: rtl/cmm_pkg.sv
// Shared widths, depth and types of the coverage map max-merge block.
package cmm_pkg;

  // Number of edges the maximum store holds.
  localparam int MAP_DEPTH = 65536;

  // Store address width, and count width able to hold MAP_DEPTH itself.
  localparam int ADDR_W = $clog2(MAP_DEPTH);
  localparam int CNT_W = $clog2(MAP_DEPTH + 1);

  // Fixed field widths of the request and result channels.
  localparam int BYTE_W = 8;
  localparam int EDGES_W = 17;

  typedef logic [CNT_W-1:0] count_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [BYTE_W-1:0] byte_t;

endpackage

// File: rtl/cmm_ram.sv
// Generic single-write, single-read RAM with a registered read port (read-first).
module cmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/coverage_map_max_merge_unit.sv
// A map byte is read from the store when it is accepted and merged in the cycle after;
// the result of a map's last byte enters the result register or skid at that merge.
// One byte is taken per cycle while hit_stall is low, over the single store read port.
// A waiting result stalls requests only once the next map's result is ready behind it,
// and that stall lasts until the waiting result is taken.
// Synchronous reset clears the primed flag, recorded length and counters; the store
// itself is not cleared, since the first map writes every entry that is later read.
module coverage_map_max_merge_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         hit_valid,
  output logic                         hit_stall,
  input  logic [cmm_pkg::BYTE_W-1:0]   hit_count_byte,
  input  logic                         end_of_map,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic                         new_coverage,
  output logic [cmm_pkg::EDGES_W-1:0]  nonzero_edges
);
  import cmm_pkg::*;

  // Payload of a byte on its way from the read to the merge.
  typedef struct packed {
    byte_t  hit;
    addr_t  addr;
    logic   take;
    logic   load;
    logic   last;
    count_t tally;
    logic   fwd;
    byte_t  fwd_data;
  } stage_t;

  typedef struct packed {
    logic                 new_cov;
    logic [EDGES_W-1:0]   edges;
  } result_t;

  logic    primed;
  count_t  map_length;
  count_t  position;
  count_t  tally;
  logic    grew_acc;

  logic    s1_valid;
  stage_t  s1;
  stage_t  s1_next;

  logic    skid_valid;
  result_t skid;
  result_t res_next;

  logic    accept;
  logic    in_range;
  logic    take;
  count_t  limit;
  count_t  position_next;
  count_t  tally_next;

  byte_t   rd_data;
  byte_t   cur_max;
  logic    bigger;
  logic    wr_en;
  logic    grew_now;
  logic    s1_result;
  logic    out_free;

  // A request is held back only when a result could find no free slot.
  assign s1_result = s1_valid && s1.last;
  assign hit_stall = skid_valid || (s1_result && result_valid && result_stall);
  assign accept    = hit_valid && !hit_stall;

  // Decide whether the incoming byte falls inside the store and the recorded length.
  always_comb begin
    limit         = primed ? map_length : CNT_W'(MAP_DEPTH);
    in_range      = position < CNT_W'(MAP_DEPTH);
    take          = in_range && (position < limit);
    position_next = in_range ? position + CNT_W'(1) : position;
    tally_next    = (take && (hit_count_byte != '0)) ? tally + CNT_W'(1) : tally;
  end

  // Capture the byte; forward the merge in flight when it targets the same entry.
  always_comb begin
    s1_next.hit      = hit_count_byte;
    s1_next.addr     = position[ADDR_W-1:0];
    s1_next.take     = take;
    s1_next.load     = !primed;
    s1_next.last     = end_of_map;
    s1_next.tally    = tally_next;
    s1_next.fwd      = wr_en && (s1.addr == position[ADDR_W-1:0]);
    s1_next.fwd_data = s1.hit;
  end

  // Position and tally advance on each accepted byte; primed and length are set once.
  always_ff @(posedge clk) begin
    if (rst) begin
      primed     <= 1'b0;
      map_length <= '0;
      position   <= '0;
      tally      <= '0;
      s1_valid   <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (end_of_map) begin
          position <= '0;
          tally    <= '0;
          if (!primed) begin
            primed     <= 1'b1;
            map_length <= position_next;
          end
        end else begin
          position <= position_next;
          tally    <= tally_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
  end

  cmm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAP_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1.addr),
    .wr_data (s1.hit),
    .rd_addr (position[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // Merge: load on the first map, otherwise raise the entry when the byte is larger.
  always_comb begin
    cur_max          = s1.fwd ? s1.fwd_data : rd_data;
    bigger           = s1.hit > cur_max;
    wr_en            = s1_valid && s1.take && (s1.load || bigger);
    grew_now         = grew_acc || (s1_valid && s1.take && !s1.load && bigger);
    res_next.new_cov = s1.load || grew_now;
    res_next.edges   = EDGES_W'(s1.tally);
  end

  // The grew flag spans one map and clears after its last byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      grew_acc <= 1'b0;
    end else if (s1_valid) begin
      grew_acc <= s1.last ? 1'b0 : grew_now;
    end
  end

  // Result register with a one-entry skid behind it.
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= s1_result;
      end else begin
        result_valid <= s1_result;
      end
    end else if (s1_result) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        new_coverage  <= skid.new_cov;
        nonzero_edges <= skid.edges;
        if (s1_result) begin
          skid <= res_next;
        end
      end else if (s1_result) begin
        new_coverage  <= res_next.new_cov;
        nonzero_edges <= res_next.edges;
      end
    end else if (s1_result) begin
      skid <= res_next;
    end
  end

endmodule

// File: rtl/cmm_checker.sv
// Port-level checker for the coverage map max-merge block, bound to its top level.
module cmm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         hit_valid,
  input logic                         hit_stall,
  input logic                         end_of_map,
  input logic                         result_valid,
  input logic                         result_stall,
  input logic                         new_coverage,
  input logic [cmm_pkg::EDGES_W-1:0]  nonzero_edges
);
  import cmm_pkg::*;

  logic       first_done;
  logic [2:0] pending;
  logic       last_in;
  logic       res_out;

  assign last_in = hit_valid && !hit_stall && end_of_map;
  assign res_out = result_valid && !result_stall;

  // Track map ends taken whose results are not yet delivered, and the first result.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_done <= 1'b0;
      pending    <= '0;
    end else begin
      if (res_out) begin
        first_done <= 1'b1;
      end
      pending <= pending + {2'b00, last_in} - {2'b00, res_out};
    end
  end

  // A waiting result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(new_coverage)
      && $stable(nonzero_edges))
    else $error("result changed while stalled");

  // Every result belongs to a map whose last byte was taken.
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pending != 3'd0)
    else $error("result without a finished map");

  // The first map after reset always reports new coverage.
  a_first_new: assert property (@(posedge clk) disable iff (rst)
    result_valid && !first_done |-> new_coverage)
    else $error("first map did not report new coverage");

  // The nonzero count never exceeds the store depth.
  a_edges_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> nonzero_edges <= MAP_DEPTH)
    else $error("edge count beyond store depth");

endmodule

bind coverage_map_max_merge_unit cmm_checker u_cmm_checker (.*);
